// ===== rtl/swerve_module_kinematics_top_defines.svh =====
// Assertion macros for the swerve module kinematics block.
`ifndef SWERVE_MODULE_KINEMATICS_TOP_DEFINES_SVH
`define SWERVE_MODULE_KINEMATICS_TOP_DEFINES_SVH
// Assert that an implication holds on every clock edge outside reset.
`define SMK_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that a condition holds in the cycle after another holds.
`define SMK_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/smk_pkg.sv =====
// Package: constants and tables for the swerve module kinematics pipeline.
package smk_pkg;
  localparam int CordicSteps = 24;
  localparam int AngW = 34;
  localparam int VecW = 42;
  localparam logic [AngW-1:0] PiQ30 = 34'd3373259426;
  localparam logic [29:0] Sin45Q30 = 30'd759250125;

  // module positions around the robot center
  localparam logic [1:0] ModFrontRight = 2'd0;
  localparam logic [1:0] ModFrontLeft = 2'd1;
  localparam logic [1:0] ModBackLeft = 2'd2;
  localparam logic [1:0] ModBackRight = 2'd3;

  // atan(2^-i) in Q30 radians
  function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
    logic [AngW-1:0] v;
    unique case (i)
      5'd0: v = 34'h3243F6A8;   5'd1: v = 34'h1DAC6705;
      5'd2: v = 34'h0FADBAFC;   5'd3: v = 34'h07F56EA6;
      5'd4: v = 34'h03FEAB76;   5'd5: v = 34'h01FFD55B;
      5'd6: v = 34'h00FFFAAA;   5'd7: v = 34'h007FFF55;
      5'd8: v = 34'h003FFFEA;   5'd9: v = 34'h001FFFFD;
      5'd10: v = 34'h000FFFFF;  5'd11: v = 34'h0007FFFF;
      5'd12: v = 34'h0003FFFF;  5'd13: v = 34'h0001FFFF;
      5'd14: v = 34'h0000FFFF;  5'd15: v = 34'h00007FFF;
      5'd16: v = 34'h00003FFF;  5'd17: v = 34'h00001FFF;
      5'd18: v = 34'h00000FFF;  5'd19: v = 34'h000007FF;
      5'd20: v = 34'h000003FF;  5'd21: v = 34'h000001FF;
      5'd22: v = 34'h000000FF;  5'd23: v = 34'h0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// ===== rtl/swerve_module_kinematics_top.sv =====
// Swerve module kinematics: a pipeline from input beat to result valid.
// Throughput: one beat per cycle when not stalled; the 24-step CORDIC and the 16-step
// square root are fully pipelined, one step per stage, all stages advance together.
// A stall freezes the whole pipe; output register shows the last stage.
// rst (synchronous) clears all valid bits and loads arm_radius with 5120.
// Configuration is taken on cfg_we with no wait.
`include "swerve_module_kinematics_top_defines.svh"
module swerve_module_kinematics_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] velocity_side,
  input  logic signed [15:0] velocity_forward,
  input  logic signed [15:0] velocity_turn,
  input  logic [1:0]  module_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  steer_angle,
  output logic [15:0] wheel_speed,
  output logic        saturated
);
  localparam int N = smk_pkg::CordicSteps;
  localparam int AW = smk_pkg::AngW;
  localparam int VW = smk_pkg::VecW;
  localparam int NS = N + 7;   // total stages including output

  logic [15:0] arm_radius;
  logic        adv;
  logic [NS-1:0] vld;

  assign adv = !vld[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_radius <= 16'd5120;
      vld <= '0;
    end else begin
      if (cfg_we) arm_radius <= cfg_data;
      if (adv) vld <= {vld[NS-2:0], in_valid};
    end
  end

  // stage 0: p = turn * radius
  logic signed [32:0] p0;
  logic signed [15:0] vx0, vy0;
  logic [1:0] idx0;
  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= velocity_turn * $signed({1'b0, arm_radius});
      vx0 <= velocity_side;
      vy0 <= velocity_forward;
      idx0 <= module_index;
    end
  end

  // stage 1: rounded |p| * sin45
  logic [32:0] mag0;
  logic [62:0] prod1;
  logic neg1;
  logic signed [15:0] vx1, vy1;
  logic [1:0] idx1;
  assign mag0 = p0[32] ? 33'(-p0) : 33'(p0);
  always_ff @(posedge clk) begin
    if (adv) begin
      prod1 <= 63'(mag0) * 63'(smk_pkg::Sin45Q30) + (63'd1 << 45);
      neg1 <= p0[32];
      vx1 <= vx0; vy1 <= vy0; idx1 <= idx0;
    end
  end

  // stage 2: add rotation, saturate
  logic signed [18:0] rot2, sxw, fyw;
  logic signed [15:0] sx2, fy2;
  logic sat2;
  always_comb begin
    rot2 = neg1 ? -$signed({2'b0, prod1[62:46]}) : $signed({2'b0, prod1[62:46]});
    sxw = 19'(vx1) + ((idx1 == smk_pkg::ModFrontRight || idx1 == smk_pkg::ModBackRight) ?
                      rot2 : -rot2);
    fyw = 19'(vy1) - ((idx1 == smk_pkg::ModFrontRight || idx1 == smk_pkg::ModFrontLeft) ?
                      rot2 : -rot2);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sx2 <= (sxw > 19'sd32767) ? 16'sh7fff : (sxw < -19'sd32768) ? 16'sh8000 : sxw[15:0];
      fy2 <= (fyw > 19'sd32767) ? 16'sh7fff : (fyw < -19'sd32768) ? 16'sh8000 : fyw[15:0];
      sat2 <= (sxw > 19'sd32767) || (sxw < -19'sd32768) ||
              (fyw > 19'sd32767) || (fyw < -19'sd32768);
    end
  end

  // stage 3: CORDIC pre-rotation, square sum
  logic signed [VW-1:0] ca [0:N];
  logic signed [VW-1:0] cb [0:N];
  logic signed [AW-1:0] cacc [0:N];
  logic [31:0] rad [0:N];
  logic [15:0] root [0:N];
  logic [31:0] rem [0:N];
  logic sat_p [0:N];
  logic zero_p [0:N];
  always_ff @(posedge clk) begin
    if (adv) begin
      if (fy2 < 0) begin
        ca[0] <= -(VW'(sx2) <<< 20);
        cb[0] <= -(VW'(fy2) <<< 20);
        cacc[0] <= (sx2 >= 0) ? $signed(smk_pkg::PiQ30) : -$signed(smk_pkg::PiQ30);
      end else begin
        ca[0] <= VW'(sx2) <<< 20;
        cb[0] <= VW'(fy2) <<< 20;
        cacc[0] <= '0;
      end
      rad[0] <= 32'(sx2 * sx2) + 32'(fy2 * fy2);
      root[0] <= '0;
      rem[0] <= '0;
      sat_p[0] <= sat2;
      zero_p[0] <= (sx2 == 0) && (fy2 == 0);
    end
  end

  // CORDIC and restoring square root, one step per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [VW-1:0] da, db;
    logic [33:0] trial, remsh;
    assign da = ca[i] >>> i;
    assign db = cb[i] >>> i;
    assign remsh = (i < 16) ? {rem[i], rad[i][31:30]} : 34'(rem[i]);
    assign trial = {16'b0, root[i], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ca[i] > 0) begin
          cb[i+1] <= cb[i] + da; ca[i+1] <= ca[i] - db;
          cacc[i+1] <= cacc[i] + $signed(smk_pkg::atan_lut(5'(i)));
        end else begin
          cb[i+1] <= cb[i] - da; ca[i+1] <= ca[i] + db;
          cacc[i+1] <= cacc[i] - $signed(smk_pkg::atan_lut(5'(i)));
        end
        if (i < 16) begin
          rad[i+1] <= rad[i] << 2;
          if (remsh >= trial) begin
            rem[i+1] <= 32'(remsh - trial);
            root[i+1] <= {root[i][14:0], 1'b1};
          end else begin
            rem[i+1] <= remsh[31:0];
            root[i+1] <= {root[i][14:0], 1'b0};
          end
        end else begin
          rad[i+1] <= rad[i]; rem[i+1] <= rem[i]; root[i+1] <= root[i];
        end
        sat_p[i+1] <= sat_p[i];
        zero_p[i+1] <= zero_p[i];
      end
    end
  end

  // degree scale: product register, then divide by 10*2^30 via magnitude
  logic signed [AW+10:0] dprod;
  logic [15:0] root_d;
  logic sat_d, zero_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      dprod <= cacc[N] * $signed(11'sd573);
      root_d <= root[N]; sat_d <= sat_p[N]; zero_d <= zero_p[N];
    end
  end

  // |dprod| >> 30 registered with its sign
  logic [AW+10:0] dmag;
  logic [14:0] q30;
  logic dneg;
  logic [15:0] root_q;
  logic sat_q, zero_q;
  assign dmag = dprod[AW+10] ? -dprod : dprod;
  always_ff @(posedge clk) begin
    if (adv) begin
      q30 <= 15'(dmag >> 30);
      dneg <= dprod[AW+10];
      root_q <= root_d; sat_q <= sat_d; zero_q <= zero_d;
    end
  end

  // divide by 10 via reciprocal, restore sign, wrap into 0..359
  logic [31:0] rq;
  logic [8:0] qd;
  logic signed [10:0] degs;
  always_comb begin
    rq   = 32'(q30) * 32'd52429;
    qd   = 9'(rq >> 19);
    if (q30 - 15'(qd) * 15'd10 >= 15'd10) qd = qd + 9'd1;
    degs = dneg ? -$signed({2'b0, qd}) : $signed({2'b0, qd});
    if (degs < 0) degs = degs + 11'sd360;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      steer_angle <= zero_q ? 9'd0 : degs[8:0];
      wheel_speed <= root_q;
      saturated <= sat_q;
    end
  end

  `SMK_ASSERT_IMP(a_out_range, clk, rst, out_valid, steer_angle < 9'd360)
  `SMK_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `SMK_ASSERT_IMP(a_ready, clk, rst, !out_valid, in_ready)
endmodule

// ===== test/swerve_module_kinematics_top_tb.sv =====
// Testbench for the swerve module kinematics block: predicted steer, speed and clip flag.
`timescale 1ns / 100ps
module swerve_module_kinematics_top_tb;

  localparam int Latency = 31;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [8:0]  angle;
    logic [15:0] speed;
    logic        clip;
  } kin_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] velocity_side = '0;
  logic signed [15:0] velocity_forward = '0;
  logic signed [15:0] velocity_turn = '0;
  logic [1:0] module_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [8:0] steer_angle;
  logic [15:0] wheel_speed;
  logic saturated;

  kin_result_t pending_kin[$];
  logic [15:0] radius_q88;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int fail_count = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int cycle_count = 0;

  swerve_module_kinematics_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .velocity_side(velocity_side), .velocity_forward(velocity_forward),
    .velocity_turn(velocity_turn), .module_index(module_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .steer_angle(steer_angle), .wheel_speed(wheel_speed), .saturated(saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor shift for signed values
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int clip_word(int v, ref bit flag);
    if (v > 32767) begin
      flag = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      flag = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  // angle in Q30 radians from a vectoring CORDIC
  function automatic longint heading_q30(int num, int den);
    longint a, b, acc, da, db;
    a = longint'(num) * 1048576;
    b = longint'(den) * 1048576;
    acc = 0;
    if (b < 0) begin
      acc = (a >= 0) ? longint'(smk_pkg::PiQ30) : -longint'(smk_pkg::PiQ30);
      a = -a;
      b = -b;
    end
    for (int i = 0; i < smk_pkg::CordicSteps; i++) begin
      da = shr_floor(a, i);
      db = shr_floor(b, i);
      if (a > 0) begin
        b += da; a -= db; acc += longint'(smk_pkg::atan_lut(5'(i)));
      end else begin
        b -= da; a += db; acc -= longint'(smk_pkg::atan_lut(5'(i)));
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic kin_result_t module_kinematics(int vx, int vy, int vz, logic [1:0] idx);
    kin_result_t r;
    longint p, theta;
    longint unsigned mag;
    int rot, cs, sn, sx, fy, deg;
    bit clipped;
    p = longint'(vz) * longint'(radius_q88);
    mag = (p < 0) ? -p : p;
    rot = int'((mag * 64'd759250125 + (64'd1 << 45)) >> 46);
    if (p < 0) rot = -rot;
    cs = (idx == smk_pkg::ModFrontRight || idx == smk_pkg::ModBackRight) ? 1 : -1;
    sn = (idx == smk_pkg::ModFrontRight || idx == smk_pkg::ModFrontLeft) ? 1 : -1;
    clipped = 1'b0;
    sx = clip_word(vx + cs * rot, clipped);
    fy = clip_word(vy - sn * rot, clipped);
    deg = 0;
    if (sx != 0 || fy != 0) begin
      theta = heading_q30(sx, fy);
      deg = int'((theta * 573) / (64'sd10 * 64'sd1073741824));
      if (deg < 0) deg += 360;
    end
    r.angle = 9'(deg);
    r.speed = 16'(root_floor(longint'(sx) * sx + longint'(fy) * fy));
    r.clip = clipped;
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("swerve_module_kinematics_top_tb failed");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    kin_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_kin.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_kin.pop_front();
        beats_checked++;
        if (steer_angle !== exp_r.angle) begin
          $error("steer_angle expected %0d actual %0d", exp_r.angle, steer_angle);
          fail_count++;
        end
        if (wheel_speed !== exp_r.speed) begin
          $error("wheel_speed expected %0d actual %0d", exp_r.speed, wheel_speed);
          fail_count++;
        end
        if (saturated !== exp_r.clip) begin
          $error("saturated expected %0d actual %0d", exp_r.clip, saturated);
          fail_count++;
        end
      end
    end
  end

  task automatic send_beat(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz, logic [1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    velocity_side <= vx;
    velocity_forward <= vy;
    velocity_turn <= vz;
    module_index <= idx;
    pending_kin.push_back(module_kinematics(int'($signed(vx)), int'($signed(vy)),
                                            int'($signed(vz)), idx));
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_kin.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_radius(logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    radius_q88 = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    logic [15:0] edge_vals[6];
    edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
    // zero vector, straight back, plain axes
    send_beat(16'd0, 16'd0, 16'd0, smk_pkg::ModFrontRight);
    send_beat(16'd0, -16'sd100, 16'd0, smk_pkg::ModFrontLeft);
    send_beat(16'd100, 16'd0, 16'd0, smk_pkg::ModBackLeft);
    send_beat(-16'sd100, 16'd0, 16'd0, smk_pkg::ModBackRight);
    send_beat(16'd0, 16'd250, 16'd0, smk_pkg::ModFrontRight);
    // extremes of each field, every module
    for (int i = 0; i < 6; i++)
      send_beat(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6], 2'(i));
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, smk_pkg::ModFrontRight);
    send_beat(16'h8000, 16'h8000, 16'h8000, smk_pkg::ModBackLeft);
    send_beat(16'h8000, 16'h7FFF, 16'h8000, smk_pkg::ModFrontLeft);
    send_beat(16'h7FFF, 16'h8000, 16'h7FFF, smk_pkg::ModBackRight);
    // pure rotation on every module
    for (int m = 0; m < 4; m++) send_beat(16'd0, 16'd0, 16'd256, 2'(m));
    drain_pipe();
  endtask

  task automatic test_random(int count);
    logic [15:0] vz;
    for (int n = 0; n < count; n++) begin
      // mostly moderate commands, some full-range
      vz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(1024)) - 512);
      if ($urandom_range(3) == 0)
        send_beat(16'($urandom), 16'($urandom), vz, 2'($urandom));
      else
        send_beat(16'($urandom_range(4000) - 2000), 16'($urandom_range(4000) - 2000), vz,
                  2'($urandom));
    end
    drain_pipe();
  endtask

  task automatic test_backpressure();
    hold_off <= 200;
    @(posedge clk);
    test_random(150);
  endtask

  initial begin
    radius_q88 = 16'd5120;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 22; recv_idle_pct = 73;
    test_directed();
    write_radius(16'd0);
    test_random(400);
    send_idle_pct = 73; recv_idle_pct = 22;
    write_radius(16'hFFFF);
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_radius(16'd5120);
    test_random(500);
    write_radius(16'($urandom));
    test_backpressure();
    write_radius(16'd1);
    test_random(280);

    $display("Sent %0d command beats, checked %0d results over several radius settings,",
             beats_sent, beats_checked);
    $display("with idle mixes on both sides and one long output hold-off.");
    if (fail_count == 0 && pending_kin.size() == 0)
      $display("swerve_module_kinematics_top_tb passed");
    else
      $display("swerve_module_kinematics_top_tb failed");
    $finish;
  end
endmodule
